// ----- rtl/eeb_pkg.sv -----
// Shared types for the extended Euclid core: controller state, commands and status.
`default_nettype none

package eeb_pkg;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } eeb_state_type;

   typedef struct packed {
      logic load;       // capture operand magnitudes and seed the coefficients
      logic div_start;  // clear the divider and product accumulators
      logic div_step;   // one restoring division bit
      logic update;     // rotate remainders and coefficients
      logic emit;       // load the result register
   } eeb_cmd_type;

   typedef struct packed {
      logic r1_zero;    // current divisor is zero: iteration finished
      logic out_busy;   // result register holds a transaction not yet taken
   } eeb_status_type;

endpackage

`default_nettype wire

// ----- rtl/eeb_if.sv -----
// Valid/ready channel interfaces for operand requests and results.
`default_nettype none

interface eeb_req_if #(parameter int WIDTH = 32);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] a_value;
   logic signed [WIDTH-1:0] b_value;

   modport source (output valid, output a_value, output b_value, input ready);
   modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface eeb_rsp_if #(parameter int WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [WIDTH-1:0]      divisor;
   logic signed [WIDTH:0] coef_a;
   logic signed [WIDTH:0] coef_b;

   modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
   modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/eeb_ctrl.sv -----
// Sequencer for the extended Euclid iteration: accept, divide, update, emit.
`default_nettype none

module eeb_ctrl
   import eeb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire eeb_status_type status,
   output eeb_cmd_type         cmd
);

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

   eeb_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.r1_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_div_ends_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == LAST_STEP) |=> state_ff == ST_UPDATE)
      else $error("division did not end in update");

   a_zero_divisor_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.r1_zero) |=> state_ff == ST_DONE)
      else $error("zero divisor did not finish the iteration");
`endif

endmodule

`default_nettype wire

// ----- rtl/eeb_dp.sv -----
// Datapath: remainders, coefficients, bit-serial divider with product accumulators.
`default_nettype none

module eeb_dp
   import eeb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire eeb_cmd_type       cmd,
   output eeb_status_type         status,
   input  wire logic [WIDTH-1:0]  a_value,
   input  wire logic [WIDTH-1:0]  b_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WIDTH-1:0]       rsp_divisor,
   output logic [WIDTH:0]         rsp_coef_a,
   output logic [WIDTH:0]         rsp_coef_b
);

   localparam int CW = WIDTH + 1;

   logic [WIDTH-1:0] r0_ff, r1_ff, rem_ff, dvd_ff;
   logic [CW-1:0]    s0_ff, s1_ff, t0_ff, t1_ff, ps_ff, pt_ff;
   logic             a_neg_ff, b_neg_ff;
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_div_ff;
   logic [CW-1:0]    out_ca_ff, out_cb_ff;

   logic [WIDTH-1:0] a_mag, b_mag;
   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] diff;
   logic             qbit;
   logic [WIDTH-1:0] rem_in;
   logic [CW-1:0]    ps_in, pt_in;

   assign a_mag = a_value[WIDTH-1] ? (~a_value + 1'b1) : a_value;
   assign b_mag = b_value[WIDTH-1] ? (~b_value + 1'b1) : b_value;

   // restoring division step, quotient bit also feeds both q*s1 and q*t1
   assign shifted = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, r1_ff};
   assign qbit    = ~diff[WIDTH+1];
   assign rem_in  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
   assign ps_in   = {ps_ff[CW-2:0], 1'b0} + (qbit ? s1_ff : '0);
   assign pt_in   = {pt_ff[CW-2:0], 1'b0} + (qbit ? t1_ff : '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r0_ff    <= a_mag;
         r1_ff    <= b_mag;
         a_neg_ff <= a_value[WIDTH-1];
         b_neg_ff <= b_value[WIDTH-1];
         s0_ff    <= CW'(1);
         s1_ff    <= '0;
         t0_ff    <= '0;
         t1_ff    <= CW'(1);
      end else if (cmd.update) begin
         r0_ff <= r1_ff;
         r1_ff <= rem_ff;
         s0_ff <= s1_ff;
         s1_ff <= s0_ff - ps_ff;
         t0_ff <= t1_ff;
         t1_ff <= t0_ff - pt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         dvd_ff <= r0_ff;
         ps_ff  <= '0;
         pt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[WIDTH-2:0], 1'b0};
         ps_ff  <= ps_in;
         pt_ff  <= pt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_div_ff <= r0_ff;
         out_ca_ff  <= a_neg_ff ? (~s0_ff + 1'b1) : s0_ff;
         out_cb_ff  <= b_neg_ff ? (~t0_ff + 1'b1) : t0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.r1_zero  = (r1_ff == '0);
   assign status.out_busy = out_valid_ff && !rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_divisor = out_div_ff;
   assign rsp_coef_a  = out_ca_ff;
   assign rsp_coef_b  = out_cb_ff;

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < r1_ff)
      else $error("partial remainder not below divisor");

   a_update_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> r1_ff < r0_ff)
      else $error("remainder did not shrink after update");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/extended_euclid_bezout_core.sv -----
// Top level of the extended Euclid core: gcd with Bezout coefficients.
//
// Usage: present a transaction on req_chan (a_value, b_value, signed WIDTH bits).
// After it completes, one transaction appears on rsp_chan with divisor =
// gcd(|a|,|b|) and coef_a, coef_b (WIDTH+1 bits, signed) such that
// divisor = a*coef_a + b*coef_b. A zero second operand returns |a|, +/-1, 0.
// Throughput: one transaction at a time. Each Euclid iteration runs a check,
// WIDTH restoring division steps on the shared divider, and an update.
// req_chan.ready is high only while the sequencer is idle; the result sits in
// an output register, so the next request is taken while a result waits.
// If rsp_chan.ready stays low, the finished result holds in the register and
// the next computation waits at its end until the register frees up.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending result; no memory needs clearing.
`default_nettype none

module extended_euclid_bezout_core
   import eeb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   eeb_req_if.sink    req_chan,
   eeb_rsp_if.source  rsp_chan
);

   eeb_cmd_type    cmd;
   eeb_status_type status;

   // sequencer: owns request handshake and division step count
   eeb_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: remainders, coefficients, divider and result register
   eeb_dp #(.WIDTH(WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .a_value     (req_chan.a_value),
      .b_value     (req_chan.b_value),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_divisor (rsp_chan.divisor),
      .rsp_coef_a  (rsp_chan.coef_a),
      .rsp_coef_b  (rsp_chan.coef_b)
   );

endmodule

`default_nettype wire
